>>> rtl/linear_probe_hash_map_assert.svh
// ----------------------------------------------------------------------------
// Linear probe hash map assertion macros
// Shared property wrappers clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// same-cycle implication
`define LPHM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPHM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lphm_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash map package
// Request/response types, codes and shared helpers.
// ----------------------------------------------------------------------------
package lphm_pkg;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic CSR_KEY_BYTES   = 1'b0;
   localparam logic CSR_VALUE_BYTES = 1'b1;

   localparam logic [31:0] HASH_C_LO = 32'h7F4A7C15;
   localparam logic [31:0] HASH_C_HI = 32'h9E3779B9;
   localparam int HASH_DIGIT = 4;
   localparam int HASH_STEPS = 32 / HASH_DIGIT;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [9:0]  live_count;
   } rsp_type;

   typedef struct packed {
      logic flag_we;
      logic data_we;
      logic live;
      logic ever;
   } store_ctl_type;

   function automatic logic [31:0] byte_mask(logic [2:0] bytes, int limit_bits);
      int b;
      int bits;
      b = int'(bytes);
      if (b < 1) b = 1;
      if (b > 4) b = 4;
      bits = b * 8;
      if (bits > limit_bits) bits = limit_bits;
      if (bits >= 32) return 32'hFFFF_FFFF;
      return (32'd1 << bits) - 32'd1;
   endfunction

endpackage

>>> rtl/lphm_hash.sv
// ----------------------------------------------------------------------------
// Linear probe hash map home slot unit
// Golden-ratio multiply hash, then reduction modulo SLOTS.
// ----------------------------------------------------------------------------
module lphm_hash #(
   parameter int SLOTS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              key,
   output logic                     done,
   output logic [$clog2(SLOTS)-1:0] home
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;

   logic [63:0] prod_lo;
   logic [63:0] prod_hi;
   logic        v1_ff;
   logic [31:0] lo_ff;
   logic [31:0] hi_ff;
   logic        v2_ff;
   logic [31:0] sum_ff;

   assign prod_lo = 64'(key) * 64'(lphm_pkg::HASH_C_LO);
   assign prod_hi = 64'(key) * 64'(lphm_pkg::HASH_C_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      lo_ff  <= prod_lo[63:32];
      hi_ff  <= prod_hi[31:0];
      sum_ff <= lo_ff + hi_ff;
   end

   generate
      if (POW2) begin : g_mask
         assign done = v2_ff;
         assign home = sum_ff[IDX_W-1:0];
      end else begin : g_mod
         localparam int REM_W = IDX_W + 1;
         localparam int STEP_W = $clog2(lphm_pkg::HASH_STEPS);
         logic              run_ff;
         logic              done_ff;
         logic [STEP_W-1:0] step_ff;
         logic [REM_W-1:0]  rem_ff;
         logic [REM_W-1:0]  rem_in;
         logic [31:0]       src_ff;

         always_comb begin
            rem_in = rem_ff;
            for (int i = 0; i < lphm_pkg::HASH_DIGIT; i++) begin
               rem_in = {rem_in[REM_W-2:0], src_ff[31-i]};
               if (rem_in >= REM_W'(SLOTS)) rem_in = rem_in - REM_W'(SLOTS);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
               step_ff <= '0;
            end else begin
               done_ff <= 1'b0;
               if (v2_ff) begin
                  run_ff  <= 1'b1;
                  step_ff <= '0;
               end else if (run_ff) begin
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == STEP_W'(lphm_pkg::HASH_STEPS - 1)) begin
                     run_ff  <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
            if (v2_ff) begin
               rem_ff <= '0;
               src_ff <= sum_ff;
            end else if (run_ff) begin
               rem_ff <= rem_in;
               src_ff <= src_ff << lphm_pkg::HASH_DIGIT;
            end
         end

         assign done = done_ff;
         assign home = rem_ff[IDX_W-1:0];
      end
   endgenerate

endmodule

>>> rtl/lphm_store.sv
// ----------------------------------------------------------------------------
// Linear probe hash map slot store
// Flag memory (live, ever used) and key/value memory, registered reads.
// ----------------------------------------------------------------------------
module lphm_store #(
   parameter int SLOTS      = 1024,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  lphm_pkg::store_ctl_type       ctl,
   input  logic [$clog2(SLOTS)-1:0]      wr_addr,
   input  logic [KEY_BITS-1:0]           wr_key,
   input  logic [VALUE_BITS-1:0]         wr_value,
   input  logic [$clog2(SLOTS)-1:0]      rd_addr,
   output logic                          rd_live,
   output logic                          rd_ever,
   output logic [KEY_BITS-1:0]           rd_key,
   output logic [VALUE_BITS-1:0]         rd_value
);

   logic [1:0]                     flag_mem [SLOTS];
   logic [KEY_BITS+VALUE_BITS-1:0] data_mem [SLOTS];
   logic [1:0]                     flag_q;
   logic [KEY_BITS+VALUE_BITS-1:0] data_q;

   always_ff @(posedge clock) begin
      if (ctl.flag_we) flag_mem[wr_addr] <= {ctl.live, ctl.ever};
      flag_q <= flag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.data_we) data_mem[wr_addr] <= {wr_key, wr_value};
      data_q <= data_mem[rd_addr];
   end

   assign rd_live  = flag_q[1];
   assign rd_ever  = flag_q[0];
   assign rd_key   = data_q[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
   assign rd_value = data_q[VALUE_BITS-1:0];

endmodule

>>> rtl/linear_probe_hash_map.sv
// ----------------------------------------------------------------------------
// Linear probe hash map
// Open-addressing key/value map with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One request at a time; busy is high while it runs. Add, lookup and delete
// first hash the key (through a modulo unit when SLOTS is not a power of
// two), then probe slot by slot, one memory read per slot; an add to a map
// holding SLOTS/2 entries answers ST_FULL without hashing. Clear answers and
// then sweeps the flag memory; the same sweep runs after reset. The
// response is a one-cycle rsp_valid pulse and cannot be held off.
module linear_probe_hash_map #(
   parameter int SLOTS      = 1024,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lphm_pkg::req_type req_data,
   output logic              rsp_valid,
   output lphm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [2:0]        csr_wdata
);

   `include "linear_probe_hash_map_assert.svh"

   localparam int IDX_W = $clog2(SLOTS);
   localparam int HALF  = SLOTS / 2;
   localparam int CNT_W = $clog2(HALF + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HASH  = 2'd1;
   localparam logic [1:0] S_PROBE = 2'd2;
   localparam logic [1:0] S_CLEAR = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [1:0]              mode_ff, mode_in;
   logic [31:0]             key_ff, key_in;
   logic [31:0]             val_ff, val_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]        free_ff, free_in;
   logic                    free_v_ff, free_v_in;
   logic [IDX_W-1:0]        clr_ff, clr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [2:0]              kb_ff, vb_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   lphm_pkg::rsp_type       rsp_ff, rsp_in;

   logic [31:0]             req_key_m;
   logic [31:0]             req_val_m;
   logic                    accept;
   logic                    add_full;
   logic                    hash_start;
   logic                    hash_done;
   logic [IDX_W-1:0]        hash_home;

   lphm_pkg::store_ctl_type ctl;
   logic [IDX_W-1:0]        wr_addr;
   logic                    rd_live, rd_ever;
   logic [KEY_BITS-1:0]     rd_key;
   logic [VALUE_BITS-1:0]   rd_value;

   logic                    hit;
   logic                    stop_miss;
   logic                    f_v;
   logic [IDX_W-1:0]        f_idx;
   logic [IDX_W-1:0]        idx_next;

   assign req_key_m = req_data.key & lphm_pkg::byte_mask(kb_ff, KEY_BITS);
   assign req_val_m = req_data.value & lphm_pkg::byte_mask(vb_ff, VALUE_BITS);
   assign accept    = start && (state_ff == S_IDLE);
   assign add_full  = (req_data.mode == lphm_pkg::MODE_ADD) && (count_ff >= CNT_W'(HALF));
   assign hash_start = accept && !add_full && (req_data.mode != lphm_pkg::MODE_CLEAR);

   lphm_hash #(.SLOTS(SLOTS)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_key_m),
      .done  (hash_done),
      .home  (hash_home)
   );

   lphm_store #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_store (
      .clock    (clock),
      .ctl      (ctl),
      .wr_addr  (wr_addr),
      .wr_key   (KEY_BITS'(key_ff)),
      .wr_value (VALUE_BITS'(val_ff)),
      .rd_addr  (idx_in),
      .rd_live  (rd_live),
      .rd_ever  (rd_ever),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   assign hit       = rd_live && (rd_key == KEY_BITS'(key_ff));
   assign stop_miss = !rd_ever || (n_ff == IDX_W'(SLOTS - 1));
   assign f_v       = free_v_ff || !rd_live;
   assign f_idx     = free_v_ff ? free_ff : idx_ff;
   assign idx_next  = (idx_ff == IDX_W'(SLOTS - 1)) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      free_in      = free_ff;
      free_v_in    = free_v_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      wr_addr      = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_data.mode;
               key_in  = req_key_m;
               val_in  = req_val_m;
               if (req_data.mode == lphm_pkg::MODE_CLEAR) begin
                  count_in     = '0;
                  clr_in       = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{lphm_pkg::ST_OK, 32'd0, 10'd0};
                  state_in     = S_CLEAR;
               end else if (add_full) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{lphm_pkg::ST_FULL, 32'd0, 10'(count_ff)};
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               idx_in    = hash_home;
               n_in      = '0;
               free_v_in = 1'b0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            if (hit || stop_miss) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (mode_ff)
                  lphm_pkg::MODE_ADD: begin
                     if (hit) begin
                        ctl.data_we = 1'b1;
                        rsp_in = '{lphm_pkg::ST_OK, 32'd0, 10'(count_ff)};
                     end else if (f_v) begin
                        wr_addr     = f_idx;
                        ctl         = '{1'b1, 1'b1, 1'b1, 1'b1};
                        count_in    = count_ff + 1'b1;
                        rsp_in = '{lphm_pkg::ST_OK, 32'd0, 10'(count_ff + 1'b1)};
                     end else begin
                        rsp_in = '{lphm_pkg::ST_FULL, 32'd0, 10'(count_ff)};
                     end
                  end
                  lphm_pkg::MODE_LOOKUP: begin
                     if (hit) rsp_in = '{lphm_pkg::ST_OK, 32'(rd_value), 10'(count_ff)};
                     else     rsp_in = '{lphm_pkg::ST_MISS, 32'd0, 10'(count_ff)};
                  end
                  default: begin
                     if (hit) begin
                        ctl      = '{1'b1, 1'b0, 1'b0, 1'b1};
                        count_in = count_ff - 1'b1;
                        rsp_in = '{lphm_pkg::ST_OK, 32'd0, 10'(count_ff - 1'b1)};
                     end else begin
                        rsp_in = '{lphm_pkg::ST_MISS, 32'd0, 10'(count_ff)};
                     end
                  end
               endcase
            end else begin
               idx_in    = idx_next;
               n_in      = n_ff + 1'b1;
               free_in   = f_idx;
               free_v_in = f_v;
            end
         end
         S_CLEAR: begin
            wr_addr     = clr_ff;
            ctl.flag_we = 1'b1;
            if (clr_ff == IDX_W'(SLOTS - 1)) state_in = S_IDLE;
            else clr_in = clr_ff + 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         kb_ff        <= 3'd4;
         vb_ff        <= 3'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               lphm_pkg::CSR_KEY_BYTES:   kb_ff <= csr_wdata;
               lphm_pkg::CSR_VALUE_BYTES: vb_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      free_ff   <= free_in;
      free_v_ff <= free_v_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LPHM_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(HALF), "live count above half")
   `LPHM_ASSERT_NOW(a_status_code, rsp_valid, rsp_data.status != 2'd3, "bad status code")
   `LPHM_ASSERT_NEXT(a_clear_zero, accept && (req_data.mode == lphm_pkg::MODE_CLEAR),
      (count_ff == '0) && rsp_valid && busy, "clear did not zero count")
   `LPHM_ASSERT_NEXT(a_probe_busy, hash_start, busy && !rsp_valid, "probe request not held")

endmodule
